>>> hdl/tssg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tssg_pkg
// Shared types and constants of the triangle span generator.
// ----------------------------------------------------------------------------
package tssg_pkg;

    localparam int COORD_W = 12;
    localparam int COLOR_W = 32;
    localparam int PROD_W  = 2 * COORD_W;

    // sorted triangle as it travels from the front part to the walker
    typedef struct packed {
        logic signed [COORD_W-1:0] x0;
        logic signed [COORD_W-1:0] y0;
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic signed [COORD_W-1:0] x2;
        logic signed [COORD_W-1:0] y2;
        logic [COLOR_W-1:0]        color;
    } job_t;

    typedef struct packed {
        logic                start;
        logic [PROD_W-1:0]   dividend;
        logic [COORD_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [PROD_W-1:0]   quo;
        logic [COORD_W-1:0]  rem;
    } div_rsp_t;

endpackage

>>> hdl/tssg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tssg_front
// Sorts the vertices by y and drops triangles that give no span.
// ----------------------------------------------------------------------------
module tssg_front #(
    parameter int MAP_HEIGHT = 32
) (
    input  logic                                push,
    output logic                                full,
    input  logic signed [tssg_pkg::COORD_W-1:0] a_x,
    input  logic signed [tssg_pkg::COORD_W-1:0] a_y,
    input  logic signed [tssg_pkg::COORD_W-1:0] b_x,
    input  logic signed [tssg_pkg::COORD_W-1:0] b_y,
    input  logic signed [tssg_pkg::COORD_W-1:0] c_x,
    input  logic signed [tssg_pkg::COORD_W-1:0] c_y,
    input  logic [tssg_pkg::COLOR_W-1:0]        color,
    input  logic                                q_full,
    output logic                                q_push,
    output tssg_pkg::job_t                      q_word
);

    localparam logic signed [tssg_pkg::COORD_W-1:0] HLIM = tssg_pkg::COORD_W'(MAP_HEIGHT);

    logic signed [tssg_pkg::COORD_W-1:0] vx [3];
    logic signed [tssg_pkg::COORD_W-1:0] vy [3];
    logic signed [tssg_pkg::COORD_W-1:0] t;
    logic                                keep;

    always_comb
    begin
        t = '0;
        vx[0] = a_x; vy[0] = a_y;
        vx[1] = b_x; vy[1] = b_y;
        vx[2] = c_x; vy[2] = c_y;
        // three compare-and-swap steps, swap only on strictly greater
        if (vy[0] > vy[1])
        begin
            t = vy[0]; vy[0] = vy[1]; vy[1] = t;
            t = vx[0]; vx[0] = vx[1]; vx[1] = t;
        end
        if (vy[0] > vy[2])
        begin
            t = vy[0]; vy[0] = vy[2]; vy[2] = t;
            t = vx[0]; vx[0] = vx[2]; vx[2] = t;
        end
        if (vy[1] > vy[2])
        begin
            t = vy[1]; vy[1] = vy[2]; vy[2] = t;
            t = vx[1]; vx[1] = vx[2]; vx[2] = t;
        end
        keep = (vy[0] < HLIM) && (vy[2] >= 0) && (vy[0] != vy[2]);
    end

    assign full          = q_full;
    assign q_push        = push && !q_full && keep;
    assign q_word.x0     = vx[0];
    assign q_word.y0     = vy[0];
    assign q_word.x1     = vx[1];
    assign q_word.y1     = vy[1];
    assign q_word.x2     = vx[2];
    assign q_word.y2     = vy[2];
    assign q_word.color  = color;

endmodule

>>> hdl/tssg_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tssg_queue
// Two-entry queue of sorted triangles between front and walker.
// ----------------------------------------------------------------------------
module tssg_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tssg_pkg::job_t wdata,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output tssg_pkg::job_t rdata
);

    tssg_pkg::job_t mem_reg [2];
    logic           wp_reg, wp_next;
    logic           rp_reg, rp_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic           do_push, do_pop;

    assign full    = cnt_reg == 2'd2;
    assign empty   = cnt_reg == 2'd0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg ^ do_push;
        rp_next  = rp_reg ^ do_pop;
        cnt_next = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wp_reg] <= wdata;
        end
    end

endmodule

>>> hdl/tssg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tssg_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tssg_div (
    input  logic               clk,
    input  logic               rst_n,
    input  tssg_pkg::div_req_t req,
    output tssg_pkg::div_rsp_t rsp
);

    localparam int PW = tssg_pkg::PROD_W;
    localparam int DW = tssg_pkg::COORD_W;
    localparam int CNT_W = $clog2(PW + 1);

    logic [PW-1:0]    dvd_reg;
    logic [DW-1:0]    rem_reg;
    logic [DW-1:0]    dsr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DW:0]      sh;
    logic             ge;

    always_comb
    begin
        sh = {rem_reg, dvd_reg[PW-1]};
        ge = sh >= {1'b0, dsr_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(PW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            dsr_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            // quotient bits shift in behind the dividend
            dvd_reg <= {dvd_reg[PW-2:0], ge};
            rem_reg <= ge ? DW'(sh - {1'b0, dsr_reg}) : sh[DW-1:0];
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = dvd_reg;
    assign rsp.rem  = rem_reg;

endmodule

>>> hdl/tssg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tssg_back
// Row walker: edge setup by division, then one span per cycle unless stalled.
// ----------------------------------------------------------------------------
module tssg_back #(
    parameter int MAP_WIDTH  = 64,
    parameter int MAP_HEIGHT = 32,
    parameter int CW         = 6,
    parameter int RW         = 5
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_empty,
    output logic                         q_pop,
    input  tssg_pkg::job_t               q_word,
    output tssg_pkg::div_req_t           dreq,
    input  tssg_pkg::div_rsp_t           drsp,
    output logic                         empty,
    input  logic                         pop,
    output logic [RW-1:0]                row,
    output logic [CW-1:0]                span_start,
    output logic [CW-1:0]                span_end,
    output logic                         span_nonempty,
    output logic [tssg_pkg::COLOR_W-1:0] span_color,
    output logic                         last
);

    localparam int K  = tssg_pkg::COORD_W;
    localparam int YW = K + 1;
    localparam int XW = K + 2;
    localparam logic signed [YW-1:0] YMAX = YW'(MAP_HEIGHT - 1);
    localparam logic signed [YW-1:0] HLIM = YW'(MAP_HEIGHT);
    localparam logic signed [XW-1:0] XMAX = XW'(MAP_WIDTH - 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SETUP = 5'b00010,
        S_ISSUE = 5'b00100,
        S_WAIT  = 5'b01000,
        S_ROW   = 5'b10000
    } state_t;

    state_t                state_reg, state_next;
    logic                  half_reg;
    logic [1:0]            idx_reg;
    tssg_pkg::job_t        job_reg;
    logic signed [YW-1:0]  y_reg, bot_reg;
    // long edge
    logic signed [XW-1:0]  xl0_reg;
    logic [K-1:0]          adxl_reg, hl_reg, kl_reg, dl_reg, rl_reg, rrl_reg;
    logic [K:0]            ql_reg;
    logic                  negl_reg;
    // short edge
    logic signed [XW-1:0]  xs0_reg, whole_reg;
    logic [K-1:0]          adxs_reg, hs_reg, ks_reg, ds_reg, rs_reg, rrs_reg;
    logic [K:0]            qs_reg;
    logic                  negs_reg, sz_reg;
    // output register
    logic                  ov_reg;
    logic [RW-1:0]         orow_reg;
    logic [CW-1:0]         ost_reg, oen_reg;
    logic                  one_reg, olast_reg;
    logic [tssg_pkg::COLOR_W-1:0] ocol_reg;

    logic signed [YW-1:0]  top, bot, ys;
    logic signed [XW-1:0]  sx0, sx1, dxl, dxs;
    logic signed [XW-1:0]  xl, xs, lo, hi;
    logic                  emit, is_last;
    logic [K:0]            suml, sums;
    logic [K-1:0]          mk, ma;

    // half setup values
    always_comb
    begin
        top = half_reg ? YW'(job_reg.y1) : YW'(job_reg.y0);
        bot = half_reg ? YW'(job_reg.y2) : YW'(job_reg.y1);
        ys  = (top < 0) ? '0 : top;
        sx0 = half_reg ? XW'(job_reg.x1) : XW'(job_reg.x0);
        sx1 = half_reg ? XW'(job_reg.x2) : XW'(job_reg.x1);
        dxl = XW'(job_reg.x2) - XW'(job_reg.x0);
        dxs = sx1 - sx0;
    end

    // span for the current row
    always_comb
    begin
        xl = xl0_reg + (negl_reg ? -XW'(ql_reg) : XW'(ql_reg));
        xs = sz_reg ? whole_reg : xs0_reg + (negs_reg ? -XW'(qs_reg) : XW'(qs_reg));
        lo = (xl < xs) ? xl : xs;
        hi = (xl < xs) ? xs : xl;
        if (lo < 0)
        begin
            lo = '0;
        end
        if (hi > XMAX)
        begin
            hi = XMAX;
        end
        emit    = (state_reg == S_ROW) && (!ov_reg || pop);
        // the middle row is walked again by the lower half
        is_last = half_reg ? ((y_reg == bot_reg) || (y_reg == YMAX))
                           : ((y_reg != bot_reg) && (y_reg == YMAX));
        suml    = {1'b0, rl_reg} + {1'b0, rrl_reg};
        sums    = {1'b0, rs_reg} + {1'b0, rrs_reg};
    end

    // divider operands
    always_comb
    begin
        mk = idx_reg[1] ? ks_reg : kl_reg;
        ma = idx_reg[1] ? adxs_reg : adxl_reg;
        dreq.start    = state_reg == S_ISSUE;
        dreq.dividend = idx_reg[0] ? mk * ma : tssg_pkg::PROD_W'(ma);
        dreq.divisor  = idx_reg[1] ? (sz_reg ? K'(1) : hs_reg) : hl_reg;
    end

    assign q_pop = (state_reg == S_IDLE) && !q_empty;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                if (ys > bot)
                begin
                    state_next = half_reg ? S_IDLE : S_SETUP;
                end
                else if (ys >= HLIM)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (drsp.done)
                begin
                    state_next = (idx_reg == 2'd3) ? S_ROW : S_ISSUE;
                end
            end
            S_ROW:
            begin
                if (emit)
                begin
                    if (is_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (!half_reg && (y_reg == bot_reg))
                    begin
                        state_next = S_SETUP;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            half_reg  <= 1'b0;
            idx_reg   <= 2'd0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop)
            begin
                half_reg <= 1'b0;
            end
            else if ((state_reg == S_SETUP) && (ys > bot) && !half_reg)
            begin
                half_reg <= 1'b1;
            end
            else if (emit && !is_last && !half_reg && (y_reg == bot_reg))
            begin
                half_reg <= 1'b1;
            end
            if (state_reg == S_SETUP)
            begin
                idx_reg <= 2'd0;
            end
            else if ((state_reg == S_WAIT) && drsp.done)
            begin
                idx_reg <= idx_reg + 2'd1;
            end
            if (emit)
            begin
                ov_reg <= 1'b1;
            end
            else if (pop)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg <= q_word;
        end
        if (state_reg == S_SETUP)
        begin
            y_reg     <= ys;
            bot_reg   <= bot;
            xl0_reg   <= XW'(job_reg.x0);
            adxl_reg  <= K'(dxl < 0 ? -dxl : dxl);
            negl_reg  <= dxl < 0;
            hl_reg    <= K'(YW'(job_reg.y2) - YW'(job_reg.y0));
            kl_reg    <= K'(ys - YW'(job_reg.y0));
            xs0_reg   <= sx0;
            whole_reg <= sx1;
            adxs_reg  <= K'(dxs < 0 ? -dxs : dxs);
            negs_reg  <= dxs < 0;
            hs_reg    <= K'(bot - top);
            ks_reg    <= K'(ys - top);
            sz_reg    <= bot == top;
        end
        if ((state_reg == S_WAIT) && drsp.done)
        begin
            case (idx_reg)
                2'd0:
                begin
                    dl_reg  <= drsp.quo[K-1:0];
                    rrl_reg <= drsp.rem;
                end
                2'd1:
                begin
                    ql_reg <= drsp.quo[K:0];
                    rl_reg <= drsp.rem;
                end
                2'd2:
                begin
                    ds_reg  <= drsp.quo[K-1:0];
                    rrs_reg <= drsp.rem;
                end
                default:
                begin
                    qs_reg <= drsp.quo[K:0];
                    rs_reg <= drsp.rem;
                end
            endcase
        end
        if (emit)
        begin
            orow_reg  <= y_reg[RW-1:0];
            one_reg   <= lo <= hi;
            ost_reg   <= (lo <= hi) ? lo[CW-1:0] : '0;
            oen_reg   <= (lo <= hi) ? hi[CW-1:0] : '0;
            olast_reg <= is_last;
            ocol_reg  <= job_reg.color;
            y_reg     <= y_reg + YW'(1);
            // exact edge step: quotient and remainder move together
            if (suml >= {1'b0, hl_reg})
            begin
                rl_reg <= K'(suml - {1'b0, hl_reg});
                ql_reg <= ql_reg + {1'b0, dl_reg} + (K+1)'(1);
            end
            else
            begin
                rl_reg <= suml[K-1:0];
                ql_reg <= ql_reg + {1'b0, dl_reg};
            end
            if (sums >= {1'b0, hs_reg})
            begin
                rs_reg <= K'(sums - {1'b0, hs_reg});
                qs_reg <= qs_reg + {1'b0, ds_reg} + (K+1)'(1);
            end
            else
            begin
                rs_reg <= sums[K-1:0];
                qs_reg <= qs_reg + {1'b0, ds_reg};
            end
        end
    end

    assign empty         = !ov_reg;
    assign row           = orow_reg;
    assign span_start    = ost_reg;
    assign span_end      = oen_reg;
    assign span_nonempty = one_reg;
    assign span_color    = ocol_reg;
    assign last          = olast_reg;

    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        drsp.done |-> (state_reg == S_WAIT))
        else $error("divider finished outside wait");

    a_long_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROW) |-> (rl_reg < hl_reg))
        else $error("long edge remainder out of range");

    a_short_rem: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_ROW) && !sz_reg) |-> (rs_reg < hs_reg))
        else $error("short edge remainder out of range");

    a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && one_reg) |-> (ost_reg <= oen_reg))
        else $error("span ends out of order");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (state_reg == S_SETUP))
        else $error("triangle taken while walking");

endmodule

>>> hdl/triangle_scanline_span_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_scanline_span_generator_unit
// Scanline fill: one triangle in, one span word per row out, middle row twice.
// ----------------------------------------------------------------------------
// Input is a queue: a triangle word is taken when push is high and full low.
// Results are a queue: the oldest span word sits on the ports while empty is
// low and is taken when pop is high. last marks the final span of a triangle.
// Triangles off screen or of zero height are taken and give no word.
// The front sorts and screens triangles into a two-entry queue, so new
// triangles are taken while the walker is busy with an earlier one.
// Per half of a triangle the walker runs four divisions on a shared radix-2
// divider to set up both edges, then gives one span a cycle while the
// receiver keeps up. A stalled receiver holds the walker on the current span;
// nothing is lost. Reset clears both queues and returns the walker to idle.
// ----------------------------------------------------------------------------
module triangle_scanline_span_generator_unit #(
    parameter int MAP_WIDTH  = 64,
    parameter int MAP_HEIGHT = 32,
    localparam int CW = (MAP_WIDTH > 1) ? $clog2(MAP_WIDTH) : 1,
    localparam int RW = (MAP_HEIGHT > 1) ? $clog2(MAP_HEIGHT) : 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic signed [tssg_pkg::COORD_W-1:0] a_x,
    input  logic signed [tssg_pkg::COORD_W-1:0] a_y,
    input  logic signed [tssg_pkg::COORD_W-1:0] b_x,
    input  logic signed [tssg_pkg::COORD_W-1:0] b_y,
    input  logic signed [tssg_pkg::COORD_W-1:0] c_x,
    input  logic signed [tssg_pkg::COORD_W-1:0] c_y,
    input  logic [tssg_pkg::COLOR_W-1:0]        color,
    output logic                                empty,
    input  logic                                pop,
    output logic [RW-1:0]                       row,
    output logic [CW-1:0]                       span_start,
    output logic [CW-1:0]                       span_end,
    output logic                                span_nonempty,
    output logic [tssg_pkg::COLOR_W-1:0]        span_color,
    output logic                                last
);

    logic               q_full, q_push, q_empty, q_pop;
    tssg_pkg::job_t     q_in, q_out;
    tssg_pkg::div_req_t dreq;
    tssg_pkg::div_rsp_t drsp;

    tssg_front #(
        .MAP_HEIGHT (MAP_HEIGHT)
    ) u_front (
        .push   (push),
        .full   (full),
        .a_x    (a_x),
        .a_y    (a_y),
        .b_x    (b_x),
        .b_y    (b_y),
        .c_x    (c_x),
        .c_y    (c_y),
        .color  (color),
        .q_full (q_full),
        .q_push (q_push),
        .q_word (q_in)
    );

    tssg_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_in),
        .full  (q_full),
        .pop   (q_pop),
        .empty (q_empty),
        .rdata (q_out)
    );

    tssg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    tssg_back #(
        .MAP_WIDTH  (MAP_WIDTH),
        .MAP_HEIGHT (MAP_HEIGHT),
        .CW         (CW),
        .RW         (RW)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .q_word        (q_out),
        .dreq          (dreq),
        .drsp          (drsp),
        .empty         (empty),
        .pop           (pop),
        .row           (row),
        .span_start    (span_start),
        .span_end      (span_end),
        .span_nonempty (span_nonempty),
        .span_color    (span_color),
        .last          (last)
    );

endmodule

>>> verif/triangle_scanline_span_generator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_scanline_span_generator_unit_tb
// Self-checking bench for the scanline triangle span generator. Triangles are
// pushed from a pending queue with random gaps; each accepted triangle is
// expanded by a local span predictor into expected words, and every popped
// span word is compared field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module triangle_scanline_span_generator_unit_tb;

    localparam int SCR_W     = 64;
    localparam int SCR_H     = 32;
    localparam int N_RANDOM  = 420;
    localparam int WDOG_MAX  = 5000;
    localparam int TAIL_WAIT = 400;
    localparam int HOLD_LEN  = 500;

    typedef struct {
        logic signed [11:0] ax, ay, bx, by, cx, cy;
        logic [31:0]        col;
    } tri_t;

    typedef struct {
        logic [4:0]  row;
        logic [5:0]  x_lo;
        logic [5:0]  x_hi;
        logic        filled;
        logic [31:0] col;
        logic        fin;
    } span_t;

    logic clk;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic full, empty;
    logic signed [11:0] a_x = '0, a_y = '0, b_x = '0, b_y = '0, c_x = '0, c_y = '0;
    logic [31:0] color = '0;
    logic [4:0]  row;
    logic [5:0]  span_start, span_end;
    logic        span_nonempty, last;
    logic [31:0] span_color;

    tri_t  tri_pending[$];
    span_t spans_due[$];
    int    n_errors = 0;
    int    n_tris = 0;
    int    n_spans = 0;
    int    cyc = 0;
    int    quiet_cycles = 0;
    int    hold_left = 0;
    bit    hold_done = 0;

    triangle_scanline_span_generator_unit #(
        .MAP_WIDTH (SCR_W),
        .MAP_HEIGHT(SCR_H)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .a_x          (a_x),
        .a_y          (a_y),
        .b_x          (b_x),
        .b_y          (b_y),
        .c_x          (c_x),
        .c_y          (c_y),
        .color        (color),
        .empty        (empty),
        .pop          (pop),
        .row          (row),
        .span_start   (span_start),
        .span_end     (span_end),
        .span_nonempty(span_nonempty),
        .span_color   (span_color),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int edge_x(int x0, int dy, int dx, int h, int whole);
        if (h == 0)
            return whole;
        return x0 + (dy * dx) / h;
    endfunction

    // expand one triangle into its expected span words
    function automatic void predict_spans(tri_t t);
        int    vx[3], vy[3];
        int    pa[3] = '{0, 0, 1};
        int    pb[3] = '{1, 2, 2};
        int    tmp, total, seg, top, bot, xl, xs, lo, hi, first_new;
        bit    stop;
        span_t s;
        vx[0] = t.ax; vy[0] = t.ay;
        vx[1] = t.bx; vy[1] = t.by;
        vx[2] = t.cx; vy[2] = t.cy;
        for (int i = 0; i < 3; i++)
        begin
            if (vy[pa[i]] > vy[pb[i]])
            begin
                tmp = vy[pa[i]]; vy[pa[i]] = vy[pb[i]]; vy[pb[i]] = tmp;
                tmp = vx[pa[i]]; vx[pa[i]] = vx[pb[i]]; vx[pb[i]] = tmp;
            end
        end
        if (vy[0] >= SCR_H || vy[2] < 0)
            return;
        total = vy[2] - vy[0];
        if (total == 0)
            return;
        stop = 0;
        first_new = spans_due.size();
        for (int j = 0; j < 2 && !stop; j++)
        begin
            top = vy[j];
            bot = vy[j + 1];
            seg = bot - top;
            for (int y = top; y <= bot; y++)
            begin
                if (y < 0)
                    continue;
                if (y >= SCR_H)
                begin
                    stop = 1;
                    break;
                end
                xl = edge_x(vx[0], y - vy[0], vx[2] - vx[0], total, vx[2]);
                xs = edge_x(vx[j], y - top, vx[j + 1] - vx[j], seg, vx[j + 1]);
                lo = (xl < xs) ? xl : xs;
                hi = (xl < xs) ? xs : xl;
                if (lo < 0) lo = 0;
                if (hi > SCR_W - 1) hi = SCR_W - 1;
                s.row    = y[4:0];
                s.filled = (lo <= hi);
                s.x_lo   = s.filled ? lo[5:0] : 6'd0;
                s.x_hi   = s.filled ? hi[5:0] : 6'd0;
                s.col    = t.col;
                s.fin    = 1'b0;
                spans_due.push_back(s);
            end
        end
        if (spans_due.size() > first_new)
            spans_due[spans_due.size() - 1].fin = 1'b1;
    endfunction

    function automatic logic signed [11:0] rand_coord(bit is_y);
        if ($urandom_range(99) < 15)
            return 12'($urandom);
        if (is_y)
            return 12'($urandom_range(60) - 15);
        return 12'($urandom_range(140) - 40);
    endfunction

    function automatic tri_t mk_tri(int ax, int ay, int bx, int by, int cx, int cy);
        tri_t t;
        t.ax = 12'(ax); t.ay = 12'(ay); t.bx = 12'(bx);
        t.by = 12'(by); t.cx = 12'(cx); t.cy = 12'(cy);
        t.col = $urandom;
        return t;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        tri_t t;
        bit   go;
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else
        begin
            cyc <= cyc + 1;
            if (push && !full)
            begin
                t.ax = a_x; t.ay = a_y; t.bx = b_x; t.by = b_y;
                t.cx = c_x; t.cy = c_y; t.col = color;
                predict_spans(t);
                void'(tri_pending.pop_front());
                n_tris <= n_tris + 1;
            end
            go = tri_pending.size() > 0 &&
                 ((cyc >= 20000 && cyc < 30000) || $urandom_range(99) >= 13);
            push <= go;
            if (go)
            begin
                a_x <= tri_pending[0].ax; a_y <= tri_pending[0].ay;
                b_x <= tri_pending[0].bx; b_y <= tri_pending[0].by;
                c_x <= tri_pending[0].cx; c_y <= tri_pending[0].cy;
                color <= tri_pending[0].col;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        span_t s;
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                n_spans <= n_spans + 1;
                if (spans_due.size() == 0)
                begin
                    $display("%0t: unexpected span word row=%0d", $time, row);
                    n_errors <= n_errors + 1;
                end
                else
                begin
                    s = spans_due.pop_front();
                    if (row !== s.row || span_start !== s.x_lo || span_end !== s.x_hi ||
                        span_nonempty !== s.filled || span_color !== s.col ||
                        last !== s.fin)
                    begin
                        $display("%0t: span mismatch exp row=%0d start=%0d end=%0d ne=%0b col=%h last=%0b",
                                 $time, s.row, s.x_lo, s.x_hi, s.filled, s.col, s.fin);
                        $display("%0t:               got row=%0d start=%0d end=%0d ne=%0b col=%h last=%0b",
                                 $time, row, span_start, span_end, span_nonempty,
                                 span_color, last);
                        n_errors <= n_errors + 1;
                    end
                end
            end
            // long receiver hold once enough words have flowed
            if (!hold_done && n_spans >= 60)
            begin
                hold_done <= 1'b1;
                hold_left <= HOLD_LEN;
                pop       <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                pop       <= 1'b0;
            end
            else
            begin
                pop <= (cyc >= 20000 && cyc < 30000) || $urandom_range(99) >= 13;
            end
        end
    end

    // watchdog on handshake progress
    always @(posedge clk)
    begin
        if (rst_n && !((push && !full) || (pop && !empty)))
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WDOG_MAX)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
        else
        begin
            quiet_cycles <= 0;
        end
    end

    initial
    begin
        // extremes of the fields
        tri_pending.push_back(mk_tri(-2048, -2048, 2047, 2047, 0, 0));
        tri_pending.push_back(mk_tri(2047, -2048, -2048, 2047, 2047, 10));
        tri_pending.push_back(mk_tri(-2048, 5, 2047, 20, -2048, 31));
        // sort ties at the top and bottom vertex, and one unsorted order
        tri_pending.push_back(mk_tri(10, 5, 40, 5, 20, 20));
        tri_pending.push_back(mk_tri(10, 20, 40, 5, 20, 20));
        tri_pending.push_back(mk_tri(10, 12, 40, 12, 20, 2));
        tri_pending.push_back(mk_tri(50, 25, 5, 3, 30, 14));
        // off screen and zero height
        tri_pending.push_back(mk_tri(0, 32, 10, 40, 20, 50));
        tri_pending.push_back(mk_tri(0, -1, 10, -9, 20, -30));
        tri_pending.push_back(mk_tri(0, 7, 60, 7, 30, 7));
        // rows above the screen and bottom edge clipping
        tri_pending.push_back(mk_tri(5, -20, 60, 10, 30, 25));
        tri_pending.push_back(mk_tri(5, 20, 60, 40, 30, 45));
        tri_pending.push_back(mk_tri(5, 31, 60, 31, 30, 40));
        tri_pending.push_back(mk_tri(-5, 0, 70, 31, 30, 31));
        // empty clipped spans on either side
        tri_pending.push_back(mk_tri(-50, 2, -10, 8, -30, 14));
        tri_pending.push_back(mk_tri(70, 2, 100, 8, 90, 14));
        // flat bottom and flat top, a triangle of height one and a wide one
        tri_pending.push_back(mk_tri(0, 0, 63, 30, 0, 30));
        tri_pending.push_back(mk_tri(0, 0, 63, 0, 31, 31));
        tri_pending.push_back(mk_tri(3, 4, 9, 5, 6, 4));
        tri_pending.push_back(mk_tri(-100, 0, 200, 31, 1000, 15));
        for (int i = 0; i < N_RANDOM; i++)
            tri_pending.push_back(mk_tri(rand_coord(0), rand_coord(1), rand_coord(0),
                                         rand_coord(1), rand_coord(0), rand_coord(1)));
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        wait (tri_pending.size() == 0 && !push);
        wait (spans_due.size() == 0);
        repeat (TAIL_WAIT) @(posedge clk);
        $display("run covered %0d triangles and %0d span words", n_tris, n_spans);
        if (n_errors == 0 && spans_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
